[hw/rtl/rbrd_pkg.sv]
`default_nettype none

package rbrd_pkg;

	// Depth of the result queue between front and back
	localparam int unsigned RBRD_QDEPTH = 4;

	// Result error codes
	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_OVERFLOW = 2'd1,
		ERR_TRUNC    = 2'd2
	} err_t;

	// One decoded result as it travels through the queue
	typedef struct packed {
		err_t       error_code;
		logic       done_res;
		logic [7:0] run_length;
		logic [7:0] out_byte;
	} res_t;

	// Queue status seen by the producer and the consumer
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

`default_nettype wire

[hw/rtl/rbrd_front.sv]
`default_nettype none

module rbrd_front
	import rbrd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	input  wire logic        in_valid,
	input  wire logic [7:0]  in_byte,
	input  wire logic        in_last,
	input  wire logic        q_full,
	output logic             in_ready,
	output logic             push,
	output res_t             push_res
);

	typedef enum logic [3:0] {
		PH_HEADER  = 4'b0001,
		PH_LITERAL = 4'b0010,
		PH_REPEAT  = 4'b0100,
		PH_STOPPED = 4'b1000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  bytes_left_q, bytes_left_d;
	logic [31:0] produced_q, produced_d;
	logic [31:0] raw_size_q;

	logic        accept;
	logic [7:0]  hdr_len;
	logic [7:0]  run_len;
	logic [32:0] total;
	logic        over;
	logic        at_size;
	logic        size_reached;
	logic [7:0]  left_dec;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Run length from the header: literal count, plus one for a repeat header
	assign hdr_len = 8'd32 - {3'b000, in_byte[4:0]} + {1'b0, in_byte[6:5], 5'b00000}
		+ {7'b0000000, in_byte[7]};

	// Share one adder between header check and emission
	always_comb begin
		case (phase_q)
			PH_HEADER:  run_len = hdr_len;
			PH_LITERAL: run_len = 8'd1;
			default:    run_len = bytes_left_q;
		endcase
	end

	assign total        = {1'b0, produced_q} + {25'd0, run_len};
	assign over         = total > {1'b0, raw_size_q};
	assign at_size      = total == {1'b0, raw_size_q};
	assign size_reached = produced_q >= raw_size_q;
	assign left_dec     = bytes_left_q - 8'd1;

	// Classify the byte and decide the result
	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		produced_d   = produced_q;
		push         = 1'b0;
		push_res     = '0;
		if (accept) begin
			case (phase_q)
				PH_HEADER: begin
					if (size_reached) begin
						phase_d = PH_STOPPED;
					end else if (in_last) begin
						push                = 1'b1;
						push_res.error_code = ERR_TRUNC;
						phase_d             = PH_STOPPED;
						bytes_left_d        = 8'd0;
					end else if (over) begin
						push                = 1'b1;
						push_res.error_code = ERR_OVERFLOW;
						phase_d             = PH_STOPPED;
						bytes_left_d        = 8'd0;
					end else begin
						bytes_left_d = hdr_len;
						phase_d      = in_byte[7] ? PH_REPEAT : PH_LITERAL;
					end
				end
				PH_LITERAL, PH_REPEAT: begin
					if (phase_q == PH_LITERAL) begin
						bytes_left_d = left_dec;
						if (left_dec == 8'd0) begin
							phase_d = PH_HEADER;
						end
					end else begin
						bytes_left_d = 8'd0;
						phase_d      = PH_HEADER;
					end
					push = 1'b1;
					if (over) begin
						push_res.error_code = ERR_OVERFLOW;
						phase_d             = PH_STOPPED;
						bytes_left_d        = 8'd0;
					end else if (in_last && !at_size) begin
						push_res.error_code = ERR_TRUNC;
						phase_d             = PH_STOPPED;
						bytes_left_d        = 8'd0;
					end else begin
						produced_d          = total[31:0];
						push_res.out_byte   = in_byte;
						push_res.run_length = run_len;
						if (at_size) begin
							push_res.done_res = 1'b1;
							phase_d           = PH_STOPPED;
							bytes_left_d      = 8'd0;
						end
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// Hold decoder state and the raw size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			bytes_left_q <= 8'd0;
			produced_q   <= 32'd0;
			raw_size_q   <= 32'd0;
		end else begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			produced_q   <= produced_d;
			if (cfg_wr_en) begin
				raw_size_q <= cfg_wr_data;
			end
		end
	end

`ifndef ASSERT_OFF
	// A literal or repeat phase always has bytes still due
	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LITERAL || phase_q == PH_REPEAT) |-> bytes_left_q != 8'd0)
		else $error("run phase with no bytes left");
	// Once stopped, the decoder stays stopped until reset
	a_stopped_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_STOPPED |=> phase_q == PH_STOPPED)
		else $error("decoder left the stopped phase");
	// A result is only pushed for an accepted byte
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (in_valid && in_ready))
		else $error("push without an input transfer");
`endif

endmodule

`default_nettype wire

[hw/rtl/rbrd_queue.sv]
`default_nettype none

module rbrd_queue
	import rbrd_pkg::*;
#(
	parameter int unsigned DEPTH = RBRD_QDEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t wr_data,
	input  wire logic pop,
	output res_t      rd_data,
	output q_stat_t   stat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign stat.empty = count_q == CW'(0);
	assign stat.full  = count_q == CW'(DEPTH);
	assign rd_data    = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("push into full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue level beyond depth");
`endif

endmodule

`default_nettype wire

[hw/rtl/rbrd_back.sv]
`default_nettype none

module rbrd_back
	import rbrd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  wire res_t rd_data,
	input  wire logic out_ready,
	output logic      pop,
	output logic      out_valid,
	output res_t      out_res
);

	logic out_valid_q;
	res_t out_res_q;

	// Load the output register when it is empty or being taken
	assign pop       = !q_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= !q_empty;
		end
	end

	// Hold payload while stalled
	always_ff @(posedge clk) begin
		if (pop) begin
			out_res_q <= rd_data;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/rle_byte_run_decoder.sv]
// Byte run-length decoder.
// s_axis carries packed bytes, one per transfer; s_axis_tlast marks the final
// packed byte available. m_axis carries decoded runs: a byte value and how many
// times it repeats, with tlast set on the run that completes the raw size and
// tuser holding the error code (0 ok, 1 overflow, 2 truncated).
// cfg_wr_en/cfg_wr_data load the expected raw size; write it only while idle.
// Throughput: one packed byte per cycle while the result queue is not full.
// Header bytes give no result; every data byte gives one, as does an error,
// after which the block stops. A result is written into the queue at the
// input transfer and then loaded into the output register, which presents
// it on m_axis; while m_axis stalls, the result waits in the queue.
// A four-entry result queue and an output register part the two sides: when
// m_axis stalls, s_axis keeps accepting until the queue fills, then tready drops.
// Reset (arst_n low) clears the raw size to zero, the decoder state, the queue
// and the output valid; with raw size zero the first header stops the block.
`default_nettype none

module rle_byte_run_decoder
	import rbrd_pkg::*;
#(
	parameter int unsigned QDEPTH = RBRD_QDEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,   // raw_size
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] packed_byte
	input  wire logic        s_axis_tlast,  // last_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [7:0] out_byte, [15:8] run_length
	output logic             m_axis_tlast,  // done_res
	output logic [1:0]       m_axis_tuser   // [1:0] error_code
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	res_t    push_res;
	res_t    rd_data;
	res_t    out_res;

	rbrd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_axis_tvalid),
		.in_byte     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.q_full      (q_stat.full),
		.in_ready    (s_axis_tready),
		.push        (push),
		.push_res    (push_res)
	);

	rbrd_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_res),
		.pop     (pop),
		.rd_data (rd_data),
		.stat    (q_stat)
	);

	rbrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_stat.empty),
		.rd_data   (rd_data),
		.out_ready (m_axis_tready),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res)
	);

	// Pack the result onto the master side
	assign m_axis_tdata = {out_res.run_length, out_res.out_byte};
	assign m_axis_tlast = out_res.done_res;
	assign m_axis_tuser = out_res.error_code;

endmodule

`default_nettype wire
